[hw/rtl/stl_pkg.sv]
`default_nettype none

package stl_pkg;

  localparam int OFFSET_BITS_DEF  = 32;
  localparam int LENGTH_LIMIT_DEF = 255;

  localparam int LINE_W    = 24;
  localparam int COL_W     = 16;
  localparam int CFG_DATA_W = 24;
  localparam int VALUE_W   = 32;

  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [COL_W-1:0]  COL_MAX  = '1;

  localparam logic CFG_START_LINE   = 1'b0;
  localparam logic CFG_START_COLUMN = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_LT,
    MODE_GT,
    MODE_EQ,
    MODE_NOT,
    MODE_NUM,
    MODE_IDENT,
    MODE_DROP
  } scan_mode_t;

  typedef enum logic [4:0] {
    TK_PLUS, TK_MINUS, TK_MULT, TK_DIV, TK_COMMA, TK_SEMI,
    TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE,
    TK_LESS, TK_LESSEQ, TK_MORE, TK_MOREEQ, TK_EQ, TK_EQEQ, TK_NOTEQ,
    TK_INT, TK_IDENT, TK_KW_FUNCTION, TK_KW_IF, TK_KW_ELSE, TK_KW_RETURN,
    TK_ERROR
  } tok_kind_t;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } src_item_t;

  typedef struct packed {
    tok_kind_t           token_kind;
    logic [LINE_W-1:0]   token_line;
    logic [COL_W-1:0]    token_column;
    logic [31:0]         token_offset;
    logic [7:0]          token_length;
    logic [VALUE_W-1:0]  int_value;
    logic                last_of_run;
  } tok_item_t;

  // keyword text, left aligned, zero padded
  function automatic logic [63:0] kw_word(input logic [1:0] k);
    logic [63:0] w;
    case (k)
      2'd0:    w = "function";
      2'd1:    w = {"if", 48'h0};
      2'd2:    w = {"else", 32'h0};
      default: w = {"return", 16'h0};
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(input logic [1:0] k);
    logic [3:0] n;
    case (k)
      2'd0:    n = 4'd8;
      2'd1:    n = 4'd2;
      2'd2:    n = 4'd4;
      default: n = 4'd6;
    endcase
    return n;
  endfunction

  function automatic tok_kind_t kw_kind(input logic [1:0] k);
    tok_kind_t t;
    case (k)
      2'd0:    t = TK_KW_FUNCTION;
      2'd1:    t = TK_KW_IF;
      2'd2:    t = TK_KW_ELSE;
      default: t = TK_KW_RETURN;
    endcase
    return t;
  endfunction

  // narrow the keyword candidates by one more character
  function automatic logic [3:0] kw_take(input logic [3:0] cand, input logic pos_ok,
                                         input logic [2:0] pos, input logic [7:0] b);
    logic [3:0]  keep;
    logic [63:0] w;
    keep = '0;
    for (int k = 0; k < 4; k++) begin
      w = kw_word(2'(k));
      if (cand[k] && pos_ok && ({1'b0, pos} < kw_len(2'(k))) &&
          (w[8*(7-int'(pos)) +: 8] == b)) begin
        keep[k] = 1'b1;
      end
    end
    return keep;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/source_text_lexer_unit.sv]
`default_nettype none

// channel   direction  handshake            payload
// src       in         src_valid/src_stall  src_item (source_byte, end_of_source)
// tok       out        tok_valid/tok_stall  tok_item (one token)
// cfg       in         cfg_we               cfg_index, cfg_data
//
// one byte per cycle while src_stall is low: the scan step is combinational from
// the state registers into a four-entry token queue; the queue drains one token per cycle while tok_stall is low
// a byte that yields two tokens writes both to the queue at once; they drain one at a time
// src_stall is high while fewer than two queue entries are free
// rst clears the scanner to idle, start_line to 1, start_column to 0
// and empties the queue

module source_text_lexer_unit #(
  parameter int OFFSET_BITS  = stl_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_LIMIT = stl_pkg::LENGTH_LIMIT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         src_valid,
  output logic                              src_stall,
  input  wire stl_pkg::src_item_t           src_item,
  output logic                              tok_valid,
  input  wire logic                         tok_stall,
  output stl_pkg::tok_item_t                tok_item,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [stl_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int LEN_BITS = $clog2(LENGTH_LIMIT + 1);
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam logic [LEN_BITS-1:0] LEN_LIMIT = LEN_BITS'(LENGTH_LIMIT);

  logic [stl_pkg::LINE_W-1:0] start_line;
  logic [stl_pkg::COL_W-1:0]  start_column;

  stl_pkg::scan_mode_t        mode, mode_next;
  logic                       fresh, fresh_next;
  logic [stl_pkg::LINE_W-1:0] line_count, line_count_next;
  logic [stl_pkg::COL_W-1:0]  column_count, column_count_next;
  logic [OFFSET_BITS-1:0]     byte_offset, byte_offset_next;
  logic [OFFSET_BITS-1:0]     start_offset, start_offset_next;
  logic [stl_pkg::COL_W-1:0]  start_col, start_col_next;
  logic [LEN_BITS-1:0]        run_length, run_length_next;
  logic [stl_pkg::VALUE_W-1:0] value_acc, value_acc_next;
  logic [3:0]                 kw_cand, kw_cand_next;

  stl_pkg::tok_item_t         res0, res1;
  logic [1:0]                 res_count;

  stl_pkg::tok_item_t         queue [QDEPTH];
  logic [QPTR_W-1:0]          wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]          q_count;
  logic                       src_acc, tok_acc;

  function automatic logic pend_valid(input stl_pkg::scan_mode_t md);
    logic v;
    unique case (md)
      stl_pkg::MODE_LT, stl_pkg::MODE_GT, stl_pkg::MODE_EQ, stl_pkg::MODE_NOT,
      stl_pkg::MODE_NUM, stl_pkg::MODE_IDENT: v = 1'b1;
      default: v = 1'b0;
    endcase
    return v;
  endfunction

  function automatic stl_pkg::tok_item_t pend_item(
      input stl_pkg::scan_mode_t        md,
      input logic [stl_pkg::LINE_W-1:0] ln,
      input logic [stl_pkg::COL_W-1:0]  scol,
      input logic [OFFSET_BITS-1:0]     soff,
      input logic [LEN_BITS-1:0]        rl,
      input logic [stl_pkg::VALUE_W-1:0] acc,
      input logic [3:0]                 cand);
    stl_pkg::tok_item_t      it;
    logic [OFFSET_BITS+31:0] oe;
    logic [LEN_BITS+7:0]     le;
    oe = {32'b0, soff};
    le = {8'b0, rl};
    it.token_line   = ln;
    it.token_column = scol;
    it.token_offset = oe[31:0];
    it.token_length = 8'd1;
    it.int_value    = '0;
    it.last_of_run  = 1'b0;
    unique case (md)
      stl_pkg::MODE_LT:  it.token_kind = stl_pkg::TK_LESS;
      stl_pkg::MODE_GT:  it.token_kind = stl_pkg::TK_MORE;
      stl_pkg::MODE_EQ:  it.token_kind = stl_pkg::TK_EQ;
      stl_pkg::MODE_NOT: it.token_kind = stl_pkg::TK_NOTEQ;
      stl_pkg::MODE_NUM: begin
        it.token_kind   = stl_pkg::TK_INT;
        it.token_length = le[7:0];
        it.int_value    = acc;
      end
      default: begin
        it.token_kind   = stl_pkg::TK_IDENT;
        it.token_length = le[7:0];
        for (int k = 0; k < 4; k++) begin
          if (cand[k] && (rl == LEN_BITS'(stl_pkg::kw_len(2'(k))))) begin
            it.token_kind = stl_pkg::kw_kind(2'(k));
          end
        end
      end
    endcase
    return it;
  endfunction

  // scan step for one byte
  always_comb begin
    logic [7:0]          b;
    logic                consumed, newline;
    logic                e1v, e2v, e3v;
    stl_pkg::tok_item_t  e1, e2, e3;
    logic [stl_pkg::LINE_W-1:0] ln;
    logic [stl_pkg::COL_W-1:0]  col;
    logic [OFFSET_BITS-1:0]     off;
    logic [35:0]         prod;
    logic [OFFSET_BITS+31:0] oe;

    b        = src_item.source_byte;
    consumed = 1'b0;
    newline  = 1'b0;
    e1v = 1'b0; e2v = 1'b0; e3v = 1'b0;
    ln  = fresh ? start_line : line_count;
    col = fresh ? start_column : column_count;
    off = fresh ? '0 : byte_offset;
    oe  = {32'b0, off};

    mode_next         = mode;
    start_offset_next = start_offset;
    start_col_next    = start_col;
    run_length_next   = run_length;
    value_acc_next    = value_acc;
    kw_cand_next      = kw_cand;

    e1 = pend_item(mode, ln, start_col, start_offset, run_length, value_acc, kw_cand);
    e2 = e1;
    prod = {1'b0, value_acc, 3'b000} + {3'b000, value_acc, 1'b0} + 36'(b[3:0]);

    // pending token: extend or resolve
    unique case (mode)
      stl_pkg::MODE_DROP: consumed = 1'b1;
      stl_pkg::MODE_LT, stl_pkg::MODE_GT, stl_pkg::MODE_EQ, stl_pkg::MODE_NOT: begin
        e1v = 1'b1;
        mode_next = stl_pkg::MODE_IDLE;
        if (b == "=") begin
          consumed = 1'b1;
          e1.token_length = 8'd2;
          unique case (mode)
            stl_pkg::MODE_LT: e1.token_kind = stl_pkg::TK_LESSEQ;
            stl_pkg::MODE_GT: e1.token_kind = stl_pkg::TK_MOREEQ;
            stl_pkg::MODE_EQ: e1.token_kind = stl_pkg::TK_EQEQ;
            default:          e1.token_kind = stl_pkg::TK_NOTEQ;
          endcase
        end
      end
      stl_pkg::MODE_NUM: begin
        if (b >= "0" && b <= "9") begin
          consumed = 1'b1;
          value_acc_next = (prod[35:32] != 4'd0) ? '1 : prod[31:0];
          if (run_length < LEN_LIMIT) run_length_next = run_length + 1'b1;
        end else begin
          e1v = 1'b1;
          mode_next = stl_pkg::MODE_IDLE;
        end
      end
      stl_pkg::MODE_IDENT: begin
        if ((b >= "0" && b <= "9") || (b >= "a" && b <= "z") ||
            (b >= "A" && b <= "Z") || b == "_") begin
          consumed = 1'b1;
          kw_cand_next = stl_pkg::kw_take(kw_cand, run_length[LEN_BITS-1:3] == '0,
                                          run_length[2:0], b);
          if (run_length < LEN_LIMIT) run_length_next = run_length + 1'b1;
        end else begin
          e1v = 1'b1;
          mode_next = stl_pkg::MODE_IDLE;
        end
      end
      default: ;
    endcase

    // start of a new token
    e2.token_line   = ln;
    e2.token_column = col;
    e2.token_offset = oe[31:0];
    e2.token_length = 8'd1;
    e2.int_value    = '0;
    e2.last_of_run  = 1'b0;
    e2.token_kind   = stl_pkg::TK_ERROR;
    if (!consumed) begin
      case (b) inside
        "+": begin e2v = 1'b1; e2.token_kind = stl_pkg::TK_PLUS;   end
        "-": begin e2v = 1'b1; e2.token_kind = stl_pkg::TK_MINUS;  end
        "*": begin e2v = 1'b1; e2.token_kind = stl_pkg::TK_MULT;   end
        "/": begin e2v = 1'b1; e2.token_kind = stl_pkg::TK_DIV;    end
        ",": begin e2v = 1'b1; e2.token_kind = stl_pkg::TK_COMMA;  end
        ";": begin e2v = 1'b1; e2.token_kind = stl_pkg::TK_SEMI;   end
        "(": begin e2v = 1'b1; e2.token_kind = stl_pkg::TK_LPAREN; end
        ")": begin e2v = 1'b1; e2.token_kind = stl_pkg::TK_RPAREN; end
        "{": begin e2v = 1'b1; e2.token_kind = stl_pkg::TK_LBRACE; end
        "}": begin e2v = 1'b1; e2.token_kind = stl_pkg::TK_RBRACE; end
        "<", ">", "=", "!", ["0":"9"], ["a":"z"], ["A":"Z"]: begin
          start_offset_next = off;
          start_col_next    = col;
          run_length_next   = LEN_BITS'(1);
          value_acc_next    = '0;
          kw_cand_next      = 4'hF;
          case (b) inside
            "<":        mode_next = stl_pkg::MODE_LT;
            ">":        mode_next = stl_pkg::MODE_GT;
            "=":        mode_next = stl_pkg::MODE_EQ;
            "!":        mode_next = stl_pkg::MODE_NOT;
            ["0":"9"]: begin
              mode_next      = stl_pkg::MODE_NUM;
              value_acc_next = {28'b0, b[3:0]};
            end
            default: begin
              mode_next    = stl_pkg::MODE_IDENT;
              kw_cand_next = stl_pkg::kw_take(4'hF, 1'b1, 3'd0, b);
            end
          endcase
        end
        " ":  ;
        8'h0A: newline = 1'b1;
        default: begin
          e2v = 1'b1;
          e2.int_value = {24'b0, b};
          mode_next = stl_pkg::MODE_DROP;
        end
      endcase
    end

    // end of text flushes what is still pending
    e3 = pend_item(mode_next, ln, start_col_next, start_offset_next, run_length_next,
                   value_acc_next, kw_cand_next);
    fresh_next = src_item.end_of_source;
    if (src_item.end_of_source) begin
      e3v = pend_valid(mode_next);
      mode_next = stl_pkg::MODE_IDLE;
    end

    byte_offset_next = off + 1'b1;
    if (newline) begin
      line_count_next   = (ln < stl_pkg::LINE_MAX) ? ln + 1'b1 : ln;
      column_count_next = stl_pkg::COL_W'(1);
    end else begin
      line_count_next   = ln;
      column_count_next = (col < stl_pkg::COL_MAX) ? col + 1'b1 : col;
    end

    // pack up to two tokens in order
    res0 = e3;
    res1 = e3;
    if (e1v) begin
      res0 = e1;
      res1 = e2v ? e2 : e3;
    end else if (e2v) begin
      res0 = e2;
    end
    res_count = 2'(e1v) + 2'(e2v) + 2'(e3v);
    res0.last_of_run = (res_count == 2'd1);
    res1.last_of_run = 1'b1;
  end

  assign src_stall = (q_count > QCNT_W'(QDEPTH - 2));
  assign src_acc   = src_valid && !src_stall;
  assign tok_valid = (q_count != '0);
  assign tok_acc   = tok_valid && !tok_stall;
  assign tok_item  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_line   <= stl_pkg::LINE_W'(1);
      start_column <= '0;
    end else if (cfg_we) begin
      if (cfg_index == stl_pkg::CFG_START_LINE) begin
        start_line <= cfg_data[stl_pkg::LINE_W-1:0];
      end else begin
        start_column <= cfg_data[stl_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= stl_pkg::MODE_IDLE;
      fresh <= 1'b1;
    end else if (src_acc) begin
      mode  <= mode_next;
      fresh <= fresh_next;
    end
  end

  always_ff @(posedge clk) begin
    if (src_acc) begin
      line_count   <= line_count_next;
      column_count <= column_count_next;
      byte_offset  <= byte_offset_next;
      start_offset <= start_offset_next;
      start_col    <= start_col_next;
      run_length   <= run_length_next;
      value_acc    <= value_acc_next;
      kw_cand      <= kw_cand_next;
    end
  end

  // token queue
  always_ff @(posedge clk) begin
    if (src_acc && res_count != 2'd0) begin
      queue[wr_ptr] <= res0;
      if (res_count == 2'd2) queue[wr_ptr + 1'b1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (src_acc) wr_ptr <= wr_ptr + QPTR_W'(res_count);
      if (tok_acc) rd_ptr <= rd_ptr + 1'b1;
      q_count <= q_count + (src_acc ? QCNT_W'(res_count) : '0) - QCNT_W'(tok_acc);
    end
  end

endmodule

`default_nettype wire
